// ===== hw/rtl/gtl_pkg.sv =====
// shared types, constants and small tables of the time log to epoch converter
// no dependencies
package gtl_pkg;

    // request payloads
    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [63:0] epoch_millis;
        logic [2:0]  error_code;
    } out_t;

    // result codes
    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_STATUS   = 3'd1;
    localparam logic [2:0] ERR_TOKENS   = 3'd2;
    localparam logic [2:0] ERR_EPOCH    = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW = 3'd4;

    // divider sizing and divisors
    localparam int DIV_W = 32;
    localparam int DVR_W = 10;
    localparam logic [DVR_W-1:0] DVR_MS   = 10'd1000;
    localparam logic [DVR_W-1:0] DVR_MON  = 10'd12;
    localparam logic [DVR_W-1:0] DVR_YEAR = 10'd400;

    // divider operand select
    typedef enum logic [1:0] {
        DIV_MS   = 2'd0,
        DIV_MON  = 2'd1,
        DIV_YEAR = 2'd2
    } div_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic     take;
        logic     clear;
        logic     div_start;
        div_sel_t div_sel;
        logic     ld_check;
        logic     ld_ms;
        logic     ld_mon;
        logic     ld_year;
        logic     ld_era;
        logic     ld_doe;
        logic     ld_days;
        logic     ld_mul;
        logic     ld_epoch;
        logic     ld_fin;
        logic     ld_out;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic       div_done;
        logic [2:0] early_err;
    } sts_t;

    localparam int MIN_TOKENS = 7;

    // day of year at start of shifted month (march based)
    function automatic logic [8:0] doy_of(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // year of era divided by 100, year of era below 400
    function automatic logic [1:0] cent_of(input logic [8:0] yoe);
        logic [1:0] c;
        if (yoe >= 9'd300) begin
            c = 2'd3;
        end else if (yoe >= 9'd200) begin
            c = 2'd2;
        end else if (yoe >= 9'd100) begin
            c = 2'd1;
        end else begin
            c = 2'd0;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/gtl_div.sv =====
// constant divider by reciprocal multiplication, quotient and remainder registered together with done
// depends on gtl_pkg
module gtl_div
    import gtl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  div_sel_t         sel,
    output logic             done,
    output logic [DIV_W-1:0] quot,
    output logic [DVR_W-1:0] rem
);

    // reciprocals and shifts, exact for every 32-bit dividend
    localparam logic [DIV_W-1:0] RCP_MS   = 32'd274877907;
    localparam logic [DIV_W-1:0] RCP_MON  = 32'hAAAAAAAB;
    localparam logic [DIV_W-1:0] RCP_YEAR = 32'h51EB851F;
    localparam int SH_MS   = 38;
    localparam int SH_MON  = 35;
    localparam int SH_YEAR = 39;

    logic               arm_reg;
    logic               prod_v_reg;
    logic               done_reg;
    div_sel_t           sel_reg;
    logic [DIV_W-1:0]   x_reg;
    logic [DIV_W-1:0]   rcp;
    logic [2*DIV_W-1:0] prod_reg;
    logic [DIV_W-1:0]   q;
    logic [DIV_W-1:0]   qd;
    logic [DIV_W-1:0]   quo_reg;
    logic [DVR_W-1:0]   rem_reg;

    // reciprocal select, quotient from the product, quotient times divisor
    always_comb begin
        case (sel_reg)
            DIV_MS: begin
                rcp = RCP_MS;
                q   = DIV_W'(prod_reg >> SH_MS);
                qd  = DIV_W'(q * DIV_W'(DVR_MS));
            end
            DIV_MON: begin
                rcp = RCP_MON;
                q   = DIV_W'(prod_reg >> SH_MON);
                qd  = DIV_W'(q * DIV_W'(DVR_MON));
            end
            DIV_YEAR: begin
                rcp = RCP_YEAR;
                q   = DIV_W'(prod_reg >> SH_YEAR);
                qd  = DIV_W'(q * DIV_W'(DVR_YEAR));
            end
            default: begin
                rcp = RCP_MS;
                q   = DIV_W'(prod_reg >> SH_MS);
                qd  = DIV_W'(q * DIV_W'(DVR_MS));
            end
        endcase
    end

    // operand latch, product stage, result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_reg    <= 1'b0;
            prod_v_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            arm_reg    <= start;
            prod_v_reg <= arm_reg;
            done_reg   <= prod_v_reg;
        end
        if (start) begin
            x_reg   <= dividend;
            sel_reg <= sel;
        end
        prod_reg <= (2*DIV_W)'(x_reg) * (2*DIV_W)'(rcp);
        if (prod_v_reg) begin
            quo_reg <= q;
            rem_reg <= DVR_W'(x_reg - qd);
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== hw/rtl/gtl_datapath.sv =====
// byte scanner, field window and date arithmetic of the converter
// depends on gtl_pkg and gtl_div
module gtl_datapath
    import gtl_pkg::*;
#(
    parameter int MAX_TEXT_BYTES = 512,
    parameter int MAX_TOKENS     = 25
) (
    input  logic aclk,
    input  logic aresetn,
    input  in_t  s_data,
    input  cmd_t cmd,
    output sts_t sts,
    output out_t m_data
);

    localparam int POS_W = $clog2(MAX_TEXT_BYTES);
    localparam int TC_W  = $clog2(MAX_TOKENS + 1);

    localparam logic [1:0] PH_WS   = 2'd0;
    localparam logic [1:0] PH_DIG  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    localparam logic [3:0] SM_MATCHED = 4'd5;
    localparam logic [3:0] SM_CUT     = 4'd6;
    localparam logic [3:0] SM_FAIL    = 4'd15;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [29:0] DIGIT_CAP = 30'd99999999;

    localparam logic signed [18:0] ERA_DAYS   = 19'sd146097;
    localparam logic signed [20:0] EPOCH_DAYS = 21'sd719468;
    localparam logic signed [12:0] HOUR_SECS  = 13'sd3600;
    localparam logic signed [6:0]  MIN_SECS   = 7'sd60;

    function automatic logic [7:0] valid_char(input logic [3:0] p);
        logic [7:0] ch;
        case (p)
            4'd0:    ch = 8'h56;
            4'd1:    ch = 8'h41;
            4'd2:    ch = 8'h4C;
            4'd3:    ch = 8'h49;
            4'd4:    ch = 8'h44;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] a);
        return a[31] ? 32'(-a) : 32'(a);
    endfunction

    // scanner state
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [TC_W-1:0]    tok_reg, tok_next;
    logic               intok_reg, intok_next;
    logic               first_reg, first_next;
    logic               ended_reg, ended_next;
    logic [29:0]        acc_reg, acc_next;
    logic [1:0]         phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [3:0]         stat_reg, stat_next;
    logic               ovf_reg, ovf_next;
    logic [5:0]         wovf_reg, wovf_next;
    logic signed [31:0] win_reg [6];
    logic signed [31:0] win_next [6];

    // scanner next state
    always_comb begin
        logic [7:0]  c;
        logic        delim;
        logic        feed;
        logic        start;
        logic        digit;
        logic        space;
        logic        add;
        logic [3:0]  dig;
        c     = s_data.char_byte;
        delim = (c == CH_COMMA) || (first_reg && c == CH_SEMI);
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        space = (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
        dig   = c[3:0];
        feed  = 1'b0;
        start = 1'b0;
        add   = 1'b0;
        pos_next   = pos_reg;
        tok_next   = tok_reg;
        intok_next = intok_reg;
        first_next = first_reg;
        ended_next = ended_reg;
        acc_next   = acc_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        stat_next  = stat_reg;
        ovf_next   = ovf_reg;
        wovf_next  = wovf_reg;
        win_next   = win_reg;
        if (cmd.clear) begin
            pos_next   = '0;
            tok_next   = '0;
            intok_next = 1'b0;
            first_next = 1'b1;
            ended_next = 1'b0;
            acc_next   = '0;
            phase_next = PH_WS;
            neg_next   = 1'b0;
            stat_next  = '0;
            ovf_next   = 1'b0;
            wovf_next  = '0;
        end else if (cmd.take && !ended_reg) begin
            if (pos_reg >= POS_W'(MAX_TEXT_BYTES - 1) || c == 8'h00) begin
                ended_next = 1'b1;
            end else begin
                pos_next = pos_reg + 1'b1;
                if (intok_reg) begin
                    if (delim) begin
                        intok_next = 1'b0;
                        first_next = 1'b0;
                    end else begin
                        feed = 1'b1;
                    end
                end else if (!delim && tok_reg < TC_W'(MAX_TOKENS)) begin
                    // a new token opens, the previous one enters the window
                    if (tok_reg != '0) begin
                        for (int i = 0; i < 5; i++) begin
                            win_next[i] = win_reg[i+1];
                        end
                        win_next[5] = neg_reg ? -$signed({2'b00, acc_reg})
                                              : $signed({2'b00, acc_reg});
                        wovf_next = {ovf_reg, wovf_reg[5:1]};
                    end
                    tok_next   = tok_reg + 1'b1;
                    intok_next = 1'b1;
                    start      = 1'b1;
                    feed       = 1'b1;
                end
            end
        end
        if (start) begin
            acc_next   = '0;
            phase_next = PH_WS;
            neg_next   = 1'b0;
            stat_next  = '0;
            ovf_next   = 1'b0;
        end
        if (feed) begin
            // number reader
            case (phase_next)
                PH_WS: begin
                    if (!space) begin
                        if (c == CH_PLUS || c == CH_MINUS) begin
                            phase_next = PH_DIG;
                            neg_next   = (c == CH_MINUS);
                        end else if (digit) begin
                            phase_next = PH_DIG;
                            add        = 1'b1;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_DIG: begin
                    if (digit) begin
                        add = 1'b1;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                default: ;
            endcase
            if (add && !ovf_next) begin
                if (acc_next > DIGIT_CAP) begin
                    ovf_next = 1'b1;
                end else begin
                    acc_next = 30'(acc_next * 30'd10 + 30'(dig));
                end
            end
            // status matcher
            if (stat_next != SM_CUT && stat_next != SM_FAIL) begin
                if (c == CH_NL) begin
                    stat_next = (stat_next == SM_MATCHED) ? SM_CUT : SM_FAIL;
                end else if (stat_next < SM_MATCHED && c == valid_char(stat_next)) begin
                    stat_next = stat_next + 4'd1;
                end else begin
                    stat_next = SM_FAIL;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            tok_reg   <= '0;
            intok_reg <= 1'b0;
            first_reg <= 1'b1;
            ended_reg <= 1'b0;
            acc_reg   <= '0;
            phase_reg <= PH_WS;
            neg_reg   <= 1'b0;
            stat_reg  <= '0;
            ovf_reg   <= 1'b0;
            wovf_reg  <= '0;
        end else begin
            pos_reg   <= pos_next;
            tok_reg   <= tok_next;
            intok_reg <= intok_next;
            first_reg <= first_next;
            ended_reg <= ended_next;
            acc_reg   <= acc_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            stat_reg  <= stat_next;
            ovf_reg   <= ovf_next;
            wovf_reg  <= wovf_next;
        end
        win_reg <= win_next;
    end

    // early error decision, in priority order
    logic [2:0] early_err;

    always_comb begin
        if (tok_reg < TC_W'(MIN_TOKENS)) begin
            early_err = ERR_TOKENS;
        end else if (wovf_reg != '0) begin
            early_err = ERR_OVERFLOW;
        end else if (stat_reg != SM_MATCHED && stat_reg != SM_CUT) begin
            early_err = ERR_STATUS;
        end else begin
            early_err = ERR_OK;
        end
    end

    // shared divider
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic [DVR_W-1:0] div_rem;
    logic [DIV_W-1:0] div_dvd;
    logic signed [31:0] mon;
    logic signed [31:0] y_reg;

    assign mon = win_reg[1] - 32'sd1;

    always_comb begin
        case (cmd.div_sel)
            DIV_MS: begin
                div_dvd = abs32(win_reg[5]);
            end
            DIV_MON: begin
                div_dvd = abs32(mon);
            end
            DIV_YEAR: begin
                div_dvd = abs32(y_reg);
            end
            default: begin
                div_dvd = '0;
            end
        endcase
    end

    gtl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .sel      (cmd.div_sel),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign sts = '{div_done: div_done, early_err: early_err};

    // conversion registers
    logic signed [31:0] sec_reg;
    logic signed [10:0] msr_reg;
    logic signed [31:0] yadj_reg;
    logic [3:0]         m_reg;
    logic signed [31:0] era_reg;
    logic [8:0]         yoe_reg;
    logic signed [47:0] eram_reg;
    logic [17:0]        doe_reg;
    logic signed [32:0] dm1_reg;
    logic signed [47:0] days_reg;
    logic signed [63:0] pd_reg;
    logic signed [44:0] ph_reg;
    logic signed [38:0] pm_reg;
    logic signed [63:0] epoch_reg;
    logic [63:0]        fin_reg;
    logic [2:0]         err_reg;
    out_t               out_reg;

    logic               rnz;
    logic signed [31:0] q_s;
    logic signed [31:0] q_up;
    logic [3:0]         mp;
    logic signed [50:0] era_prod;
    logic signed [63:0] days_x;
    logic signed [63:0] day_prod;
    logic [63:0]        ms_prod;

    assign rnz      = (div_rem != '0);
    assign q_s      = $signed(div_quot);
    assign q_up     = q_s + 32'sd1;
    assign mp       = (m_reg >= 4'd3) ? (m_reg - 4'd3) : (m_reg + 4'd9);
    assign era_prod = 51'(era_reg) * 51'(ERA_DAYS);
    assign days_x   = 64'(days_reg);
    // times 86400 and times 1000 as sums and differences of shifts
    assign day_prod = (days_x <<< 16) + (days_x <<< 14) + (days_x <<< 12)
                      + (days_x <<< 8) + (days_x <<< 7);
    assign ms_prod  = (64'(epoch_reg) << 10) - (64'(epoch_reg) << 4)
                      - (64'(epoch_reg) << 3);

    always_ff @(posedge aclk) begin
        // truncating split of the millisecond field
        if (cmd.ld_ms) begin
            sec_reg <= win_reg[5][31] ? -q_s : q_s;
            msr_reg <= win_reg[5][31] ? -$signed({1'b0, div_rem}) : $signed({1'b0, div_rem});
        end
        // floor split of month minus one into years
        if (cmd.ld_mon) begin
            if (mon[31] && rnz) begin
                yadj_reg <= -q_up;
                m_reg    <= 4'(5'd13 - 5'(div_rem[3:0]));
            end else if (mon[31]) begin
                yadj_reg <= -q_s;
                m_reg    <= 4'd1;
            end else begin
                yadj_reg <= q_s;
                m_reg    <= div_rem[3:0] + 4'd1;
            end
        end
        // march based year
        if (cmd.ld_year) begin
            y_reg <= win_reg[0] + yadj_reg - ((m_reg <= 4'd2) ? 32'sd1 : 32'sd0);
        end
        // floor split of the year into eras
        if (cmd.ld_era) begin
            if (y_reg[31] && rnz) begin
                era_reg <= -q_up;
                yoe_reg <= 9'(10'd400 - div_rem);
            end else if (y_reg[31]) begin
                era_reg <= -q_s;
                yoe_reg <= '0;
            end else begin
                era_reg <= q_s;
                yoe_reg <= div_rem[8:0];
            end
        end
        // day of era and era days
        if (cmd.ld_doe) begin
            eram_reg <= 48'(era_prod);
            doe_reg  <= 18'(18'(yoe_reg) * 18'd365 + 18'(yoe_reg[8:2])
                            - 18'(cent_of(yoe_reg)) + 18'(doy_of(mp)));
            dm1_reg  <= 33'(win_reg[2]) - 33'sd1;
        end
        if (cmd.ld_days) begin
            days_reg <= eram_reg + $signed({30'd0, doe_reg}) - 48'(EPOCH_DAYS)
                        + 48'(dm1_reg);
        end
        // seconds products
        if (cmd.ld_mul) begin
            pd_reg <= day_prod;
            ph_reg <= 45'(win_reg[3]) * 45'(HOUR_SECS);
            pm_reg <= 39'(win_reg[4]) * 39'(MIN_SECS);
        end
        if (cmd.ld_epoch) begin
            epoch_reg <= pd_reg + 64'(ph_reg) + 64'(pm_reg) + 64'(sec_reg);
        end
        if (cmd.ld_fin) begin
            fin_reg <= ms_prod + 64'(msr_reg);
        end
        if (cmd.ld_out) begin
            out_reg.epoch_millis <= (err_reg == ERR_OK) ? fin_reg : 64'd0;
            out_reg.error_code   <= err_reg;
        end
    end

    // result code register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_reg <= ERR_OK;
        end else if (cmd.ld_check) begin
            err_reg <= early_err;
        end else if (cmd.ld_fin && epoch_reg == -64'sd1) begin
            err_reg <= ERR_EPOCH;
        end
    end

    assign m_data = out_reg;

endmodule

// ===== hw/rtl/gtl_ctrl.sv =====
// controller: byte intake, conversion sequence and result handshake
// depends on gtl_pkg
module gtl_ctrl
    import gtl_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_end,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [14:0] {
        S_RUN   = 15'b000000000000001,
        S_CHECK = 15'b000000000000010,
        S_MSD   = 15'b000000000000100,
        S_MSW   = 15'b000000000001000,
        S_MOND  = 15'b000000000010000,
        S_MONW  = 15'b000000000100000,
        S_YEAR  = 15'b000000001000000,
        S_YD    = 15'b000000010000000,
        S_YW    = 15'b000000100000000,
        S_DOE   = 15'b000001000000000,
        S_DAYS  = 15'b000010000000000,
        S_MUL   = 15'b000100000000000,
        S_SUM   = 15'b001000000000000,
        S_FIN   = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == S_RUN);
    assign out_free = !m_valid_reg || m_ready;

    // sequencer
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_MS;
        case (state_reg)
            S_RUN: begin
                cmd.take = s_valid;
                if (s_valid && s_end) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.ld_check = 1'b1;
                state_next = (sts.early_err != ERR_OK) ? S_OUT : S_MSD;
            end
            S_MSD: begin
                cmd.div_start = 1'b1;
                state_next = S_MSW;
            end
            S_MSW: begin
                cmd.ld_ms = sts.div_done;
                if (sts.div_done) begin
                    state_next = S_MOND;
                end
            end
            S_MOND: begin
                cmd.div_sel   = DIV_MON;
                cmd.div_start = 1'b1;
                state_next = S_MONW;
            end
            S_MONW: begin
                cmd.div_sel = DIV_MON;
                cmd.ld_mon  = sts.div_done;
                if (sts.div_done) begin
                    state_next = S_YEAR;
                end
            end
            S_YEAR: begin
                cmd.ld_year = 1'b1;
                state_next = S_YD;
            end
            S_YD: begin
                cmd.div_sel   = DIV_YEAR;
                cmd.div_start = 1'b1;
                state_next = S_YW;
            end
            S_YW: begin
                cmd.div_sel = DIV_YEAR;
                cmd.ld_era  = sts.div_done;
                if (sts.div_done) begin
                    state_next = S_DOE;
                end
            end
            S_DOE: begin
                cmd.ld_doe = 1'b1;
                state_next = S_DAYS;
            end
            S_DAYS: begin
                cmd.ld_days = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.ld_mul = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.ld_epoch = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                cmd.ld_fin = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.ld_out = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = S_RUN;
                end
            end
            default: begin
                state_next = S_RUN;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        if (cmd.ld_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_RUN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // checks
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_out |-> out_free)
        else $error("result loaded over a pending one");

    a_end_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_end) |=> (state_reg == S_CHECK))
        else $error("end of text did not start the conversion");

    a_clear_only_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (s_ready && m_valid))
        else $error("clear without a delivered result");

endmodule

// ===== hw/rtl/gps_time_log_to_epoch_ms.sv =====
// time log bytes in, unix epoch milliseconds out
// sequence: the end byte starts the result check; an early error goes straight to the output,
// a full conversion first runs three reciprocal divisions on the shared divider
// throughput: one byte per cycle while scanning; held off until the result is loaded
// reset: synchronous active-low aresetn clears the scanner and drops m_valid
// depends on gtl_pkg, gtl_ctrl, gtl_datapath, gtl_div
module gps_time_log_to_epoch_ms
    import gtl_pkg::*;
#(
    parameter int MAX_TEXT_BYTES = 512,
    parameter int MAX_TOKENS     = 25
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cmd_t cmd;
    sts_t sts;

    // sequencer
    gtl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_end   (s_data.end_of_text),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // scanner and arithmetic
    gtl_datapath #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
        .MAX_TOKENS     (MAX_TOKENS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

// ===== verif/gps_time_log_to_epoch_ms_test.sv =====
// testbench of the time log to epoch milliseconds converter: drives log bytes,
// predicts or types in each end-of-log result and compares it field by field
// depends on gtl_pkg and gps_time_log_to_epoch_ms
`timescale 1ns / 100ps

module gps_time_log_to_epoch_ms_test;
    import gtl_pkg::*;

    localparam int TEXT_LIMIT  = 511;
    localparam int TOKEN_LIMIT = 25;
    localparam int DIGIT_MAX   = 999999999;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LOG_BYTES   = 1150;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    gps_time_log_to_epoch_ms u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // predictor state of the log scanner
    int unsigned scan_pos;
    int unsigned tok_cnt;
    bit          in_tok;
    bit          first_tok;
    bit          text_done;
    int unsigned num_acc;
    bit [1:0]    num_phase;
    bit          num_neg;
    int unsigned status_prog;
    int          field_win[6];
    bit [5:0]    field_ovf;
    bit          tok_ovf;

    out_t        pending_epochs[$];
    int          fail_cnt;
    int          tx_idle;
    int          rx_idle;
    bit          rx_hold_req;
    bit          hold_done;
    int          bytes_sent;
    byte unsigned log_bytes[$];

    // directed logs, expected result typed in
    typedef struct {
        string txt;
        out_t  want;
    } log_row_t;
    log_row_t directed_logs[2];

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    int unsigned cycle_cnt;
    initial cycle_cnt = 0;
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic void clear_scan();
        scan_pos    = 0;
        tok_cnt     = 0;
        in_tok      = 0;
        first_tok   = 1;
        text_done   = 0;
        num_acc     = 0;
        num_phase   = 0;
        num_neg     = 0;
        status_prog = 0;
        foreach (field_win[i]) field_win[i] = 0;
        field_ovf   = '0;
        tok_ovf     = 0;
    endfunction

    function automatic void add_digit(int unsigned d);
        if (tok_ovf) return;
        if (num_acc > (DIGIT_MAX - d) / 10) tok_ovf = 1;
        else num_acc = num_acc * 10 + d;
    endfunction

    // atoi style number reader
    function automatic void feed_number(byte unsigned c);
        bit digit;
        bit space;
        digit = (c >= "0" && c <= "9");
        space = (c == " " || (c >= 9 && c <= 13));
        if (num_phase == 0) begin
            if (space) return;
            if (c == "+" || c == "-") begin
                num_phase = 1;
                num_neg   = (c == "-");
            end else if (digit) begin
                num_phase = 1;
                add_digit(c - "0");
            end else begin
                num_phase = 2;
            end
        end else if (num_phase == 1) begin
            if (digit) add_digit(c - "0");
            else num_phase = 2;
        end
    endfunction

    // status text match, 6 means matched and cut at newline, 15 failed
    function automatic void feed_status(byte unsigned c);
        string ref_txt;
        ref_txt = "VALID";
        if (status_prog == 6 || status_prog == 15) return;
        if (c == 8'h0a) status_prog = (status_prog == 5) ? 6 : 15;
        else if (status_prog < 5 && c == ref_txt[status_prog]) status_prog++;
        else status_prog = 15;
    endfunction

    function automatic void take_byte(byte unsigned c);
        bit delim;
        int v;
        delim = (c == ",") || (first_tok && c == ";");
        if (in_tok) begin
            if (delim) begin
                in_tok    = 0;
                first_tok = 0;
            end else begin
                feed_number(c);
                feed_status(c);
            end
            return;
        end
        if (delim || tok_cnt >= TOKEN_LIMIT) return;
        // shift the finished token into the field window
        if (tok_cnt > 0) begin
            v = int'(num_acc);
            for (int i = 0; i < 5; i++) field_win[i] = field_win[i+1];
            field_win[5] = num_neg ? -v : v;
            field_ovf = {tok_ovf, field_ovf[5:1]};
        end
        num_acc     = 0;
        num_phase   = 0;
        num_neg     = 0;
        status_prog = 0;
        tok_ovf     = 0;
        tok_cnt++;
        in_tok = 1;
        feed_number(c);
        feed_status(c);
    endfunction

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint days_from_civil(longint y, longint m);
        longint era, yoe, mp, doy, doe;
        if (m <= 2) y--;
        era = floor_div(y, 400);
        yoe = y - era * 400;
        mp  = (m + 9) % 12;
        doy = (153 * mp + 2) / 5;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic out_t convert_log();
        out_t r;
        longint yr, mon, dy, hr, mi, ms, sec, yadj, days, epoch;
        r.epoch_millis = '0;
        if (tok_cnt < 7) begin
            r.error_code = ERR_TOKENS;
            return r;
        end
        if (field_ovf != 0) begin
            r.error_code = ERR_OVERFLOW;
            return r;
        end
        if (!(status_prog == 5 || status_prog == 6)) begin
            r.error_code = ERR_STATUS;
            return r;
        end
        yr   = field_win[0];
        mon  = longint'(field_win[1]) - 1;
        dy   = field_win[2];
        hr   = field_win[3];
        mi   = field_win[4];
        ms   = field_win[5];
        sec  = ms / 1000;
        ms   = ms % 1000;
        yadj = floor_div(mon, 12);
        yr   = yr + yadj;
        mon  = mon - yadj * 12;
        days = days_from_civil(yr, mon + 1) + (dy - 1);
        epoch = days * 86400 + hr * 3600 + mi * 60 + sec;
        if (epoch == -1) begin
            r.error_code = ERR_EPOCH;
            return r;
        end
        r.epoch_millis = epoch * 1000 + ms;
        r.error_code   = ERR_OK;
        return r;
    endfunction

    // one accepted byte through the predictor
    function automatic bit predict_byte(in_t d, output out_t r);
        r = '0;
        if (!text_done) begin
            if (scan_pos >= TEXT_LIMIT || d.char_byte == 0) begin
                text_done = 1;
            end else begin
                scan_pos++;
                take_byte(d.char_byte);
            end
        end
        if (!d.end_of_text) return 0;
        r = convert_log();
        clear_scan();
        return 1;
    endfunction

    // offer one request and wait for it to be taken
    task automatic send_byte(byte unsigned c, bit eot, bit typed, out_t want);
        in_t  d;
        out_t r;
        d.char_byte   = c;
        d.end_of_text = eot;
        if ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < tx_idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        if (predict_byte(d, r)) pending_epochs.push_back(typed ? want : r);
    endtask

    task automatic send_log(bit typed, out_t want);
        foreach (log_bytes[i])
            send_byte(log_bytes[i], i == log_bytes.size() - 1, typed, want);
        log_bytes.delete();
    endtask

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) log_bytes.push_back(s[i]);
    endfunction

    // numeric field text with sign, spacing and overflow variants
    function automatic string num_text(int lo, int hi);
        string s;
        int k;
        k = $urandom_range(99);
        if (k < 70) s = $sformatf("%0d", $urandom_range(hi, lo));
        else if (k < 78) s = $sformatf("-%0d", $urandom_range(hi, lo));
        else if (k < 84) s = $sformatf("  +%0d", $urandom_range(hi, lo));
        else if (k < 88) s = $sformatf("%0d", $urandom_range(DIGIT_MAX));
        else if (k < 91) s = $sformatf("%0d%0d", $urandom_range(9, 1), $urandom_range(DIGIT_MAX));
        else if (k < 95) s = $sformatf("%0dx7", $urandom_range(hi, lo));
        else s = "abc";
        return s;
    endfunction

    function automatic string status_text();
        case ($urandom_range(9))
            0: return "VALID\nxyz";
            1: return "VALIX";
            2: return "VALI";
            3: return "valid";
            4: return "\nVALID";
            default: return "VALID";
        endcase
    endfunction

    // one random log into the byte queue
    function automatic void build_log();
        int k;
        k = $urandom_range(99);
        if (k < 6) begin
            // noise
            repeat ($urandom_range(40, 1)) log_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        if (k < 9) begin
            // many tokens, often past the token limit
            repeat ($urandom_range(32, 20)) put_str($sformatf("%0d,", $urandom_range(99)));
            return;
        end
        if (k < 12) begin
            // short log
            repeat ($urandom_range(6, 1)) put_str($sformatf("%0d,", $urandom_range(99)));
            return;
        end
        if ($urandom_range(1)) put_str("#TIMEA,COM1;");
        if ($urandom_range(3) == 0) put_str("8,,17,");
        if (k < 40) put_str($sformatf("%0d,", $urandom_range(DIGIT_MAX)));
        else put_str($sformatf("%s,", num_text(1900, 2100)));
        put_str($sformatf("%s,,", num_text(1, 12)));
        put_str($sformatf("%s,", num_text(1, 31)));
        put_str($sformatf("%s,", num_text(0, 23)));
        put_str($sformatf("%s,", num_text(0, 59)));
        put_str($sformatf("%s,", num_text(0, 59999)));
        put_str(status_text());
        if ($urandom_range(19) == 0) begin
            log_bytes.insert($urandom_range(log_bytes.size() - 1), 8'h00);
        end
    endfunction

    // result check
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_epochs.size() == 0) begin
                $error("result with none expected: epoch_millis %0d error_code %0d",
                       m_data.epoch_millis, m_data.error_code);
                fail_cnt++;
            end else begin
                want = pending_epochs.pop_front();
                if (m_data.epoch_millis !== want.epoch_millis) begin
                    $error("epoch_millis expected %0d actual %0d",
                           want.epoch_millis, m_data.epoch_millis);
                    fail_cnt++;
                end
                if (m_data.error_code !== want.error_code) begin
                    $error("error_code expected %0d actual %0d",
                           want.error_code, m_data.error_code);
                    fail_cnt++;
                end
            end
        end
    end

    // result side ready, with one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                rx_hold_req = 0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    // stimulus
    initial begin
        int limit;
        out_t none;
        none        = '0;
        fail_cnt    = 0;
        bytes_sent  = 0;
        rx_hold_req = 0;
        hold_done   = 0;
        tx_idle     = 10;
        rx_idle     = 88;
        clear_scan();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        directed_logs[0].txt  = "A";
        directed_logs[0].want = {64'd0, ERR_TOKENS};
        directed_logs[1].txt  = "1970,1,1,0,0,-1000,VALID";
        directed_logs[1].want = {64'd0, ERR_EPOCH};
        foreach (directed_logs[i]) begin
            put_str(directed_logs[i].txt);
            send_log(1, directed_logs[i].want);
        end

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 10 : (ph == 1) ? 88 : 0;
            rx_idle = (ph == 0) ? 88 : (ph == 1) ? 10 : 0;
            limit = LOG_BYTES * (ph + 1) / 3;
            while (bytes_sent < limit) begin
                // a rare long text past the byte limit
                if ($urandom_range(199) == 0) begin
                    repeat (600) log_bytes.push_back(8'($urandom_range(255, 1)));
                end else begin
                    build_log();
                end
                send_log(0, none);
                if (ph == 0 && bytes_sent > 150 && !hold_done) begin
                    rx_hold_req = 1;
                    hold_done   = 1;
                end
            end
            // sender pauses until all results are in
            s_valid <= 1'b0;
            @(posedge aclk);
            while (pending_epochs.size() != 0) @(posedge aclk);
        end

        repeat (200) @(posedge aclk);
        if (fail_cnt == 0 && pending_epochs.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
